FILE: hdl/cprf_pkg.sv
// ----------------------------------------------------------------------------
// cprf_pkg
// Shared types and constants of the complement pair frame receiver.
// ----------------------------------------------------------------------------
package cprf_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTE   = 2'd1;

	localparam logic [BYTE_W-1:0] TIMEOUT_RESET = 8'd50;
	localparam logic [BYTE_W-1:0] HEADER_RESET  = 8'h53;
	localparam logic [BYTE_W-1:0] IDLE_FILL     = 8'hAA;
	localparam logic [BYTE_W:0]   PAIR_SUM      = 9'h0FF;

	localparam logic [1:0] PAIRS_NONE = 2'd0;
	localparam logic [1:0] PAIRS_ONE  = 2'd1;
	localparam logic [1:0] PAIRS_TWO  = 2'd2;

	typedef logic [BYTE_W-1:0] byte_t;

	typedef struct packed {
		logic  push;
		byte_t data;
	} cprf_push_t;

endpackage

FILE: hdl/complement_pair_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// complement_pair_frame_receiver_unit
// Receives tick items, tracks complement pairs and emits frame payloads.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carries one tick (byte_valid, rx_byte).
// A transaction completes at a clock edge with in_valid high and in_stall low.
// The front tracker updates its frame state in the cycle of the transaction,
// so one tick is taken every cycle while in_stall is low.
// Output channel: out_valid/out_stall carries payload. A payload produced by
// a tick is written into the registered queue at that tick's transaction.
// Payloads pass through a QUEUE_DEPTH-entry queue; in_stall rises only while
// the queue is full, so the input keeps running at one tick per cycle as long
// as the receiver drains within the queue depth.
// Configuration: cfg_we writes cfg_wdata to register cfg_index
// (0 timeout_ticks, 1 header_byte); write only while the block is idle.
// Reset: timeout_ticks 50, header_byte 0x53, empty queue, no pairs held.
// While out_stall is high the head payload holds on the output.
// ----------------------------------------------------------------------------
module complement_pair_frame_receiver_unit #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cprf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  cprf_pkg::byte_t                cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           byte_valid,
	input  cprf_pkg::byte_t                rx_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output cprf_pkg::byte_t                payload
);
	import cprf_pkg::*;

	cprf_push_t push;
	logic       full;
	logic       accept;

	assign in_stall = full;
	assign accept   = in_valid && !in_stall;

	cprf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.accept     (accept),
		.byte_valid (byte_valid),
		.rx_byte    (rx_byte),
		.push       (push)
	);

	cprf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.payload   (payload)
	);

endmodule

FILE: hdl/cprf_front.sv
// ----------------------------------------------------------------------------
// cprf_front
// Frame tracker: pair detection, timeout and header check; pushes payloads.
// ----------------------------------------------------------------------------
module cprf_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [cprf_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  cprf_pkg::byte_t                        cfg_wdata,
	input  logic                                   accept,
	input  logic                                   byte_valid,
	input  cprf_pkg::byte_t                        rx_byte,
	output cprf_pkg::cprf_push_t                   push
);
	import cprf_pkg::*;

	byte_t      timeout_ticks_q;
	byte_t      header_byte_q;
	byte_t      timeout_q;
	byte_t      prev_q;
	logic [1:0] pairs_q;
	byte_t      first_q;
	byte_t      second_q;

	byte_t      timeout_d;
	byte_t      prev_d;
	logic [1:0] pairs_d;
	byte_t      first_d;
	byte_t      second_d;
	logic       emit;
	logic       pair_hit;

	assign pair_hit = ({1'b0, rx_byte} + {1'b0, prev_q}) == PAIR_SUM;

	always_comb begin
		timeout_d = timeout_q;
		prev_d    = prev_q;
		pairs_d   = pairs_q;
		first_d   = first_q;
		second_d  = second_q;
		emit      = 1'b0;
		if (byte_valid) begin
			timeout_d = timeout_ticks_q;
			if (pair_hit) begin
				case (pairs_q)
					PAIRS_NONE: begin
						first_d = prev_q;
						pairs_d = PAIRS_ONE;
					end
					PAIRS_ONE: begin
						second_d = prev_q;
						pairs_d  = PAIRS_TWO;
					end
					default: ;
				endcase
				if (pairs_d == PAIRS_TWO && first_d == header_byte_q) begin
					emit      = 1'b1;
					timeout_d = '0;
				end
			end
			prev_d = rx_byte;
		end else if (timeout_q != '0) begin
			timeout_d = timeout_q - 8'd1;
		end
		if (timeout_d == '0) begin
			pairs_d = PAIRS_NONE;
			prev_d  = IDLE_FILL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_ticks_q <= TIMEOUT_RESET;
			header_byte_q   <= HEADER_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_wdata;
				CFG_HEADER_BYTE:   header_byte_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			prev_q    <= '0;
			pairs_q   <= PAIRS_NONE;
		end else if (accept) begin
			timeout_q <= timeout_d;
			prev_q    <= prev_d;
			pairs_q   <= pairs_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			first_q  <= first_d;
			second_q <= second_d;
		end
	end

	assign push.push = accept && emit;
	assign push.data = second_d;

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		push.push |=> (pairs_q == PAIRS_NONE && prev_q == IDLE_FILL && timeout_q == '0))
		else $error("frame accept did not clear the frame");

	a_pairs_range: assert property (@(posedge clk) disable iff (!arst_n)
		pairs_q != 2'd3)
		else $error("pair count out of range");

	a_timeout_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && timeout_d == '0) |=> (pairs_q == PAIRS_NONE && prev_q == IDLE_FILL))
		else $error("timeout did not drop the partial frame");

endmodule

FILE: hdl/cprf_queue.sv
// ----------------------------------------------------------------------------
// cprf_queue
// Payload queue; its head drives the output channel.
// ----------------------------------------------------------------------------
module cprf_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cprf_pkg::cprf_push_t push,
	output logic                 full,
	output logic                 out_valid,
	input  logic                 out_stall,
	output cprf_pkg::byte_t      payload
);
	import cprf_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	byte_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign full      = count_q == FULL_CNT;
	assign out_valid = count_q != '0;
	assign pop       = out_valid && !out_stall;
	assign payload   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.push) begin
			mem_q[wr_ptr_q] <= push.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push.push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.push |-> !full)
		else $error("push into a full queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count out of range");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push.push) |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("pop did not drain the queue");

endmodule
